// File: hw/rtl/ctvt_pkg.sv
package ctvt_pkg;

  // Largest number of peers that may take part in one round.
  localparam int unsigned MaxPeers = 15;

  localparam int unsigned TermW  = 64;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PeersW = 4;
  localparam int unsigned CntW   = 5;

  localparam logic [CntW-1:0]  CntMax = {CntW{1'b1}};
  localparam logic [TermW-1:0] TermMax = {TermW{1'b1}};
  // Wide enough for MaxPeers + 1 at the top of the parameter range.
  localparam int unsigned PartW = 9;
  localparam logic [PartW-1:0] MaxPeersW = PartW'(MaxPeers);

  typedef enum logic [KindW-1:0] {
    KIND_HB_REQ     = 3'd0,
    KIND_VOTE_REQ   = 3'd1,
    KIND_VOTE_REPLY = 3'd2,
    KIND_HB_REPLY   = 3'd3,
    KIND_ELECTION   = 3'd4,
    KIND_BROADCAST  = 3'd5,
    KIND_TIMER      = 3'd6
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [TermW-1:0]  msg_term;
    logic              granted_in;
    logic [PeersW-1:0] ready_peers;
  } in_word_t;

  typedef struct packed {
    logic [TermW-1:0] reply_term;
    logic             reply_ok;
    logic             term_advanced;
    logic             leader_seen;
    logic             elected;
    logic             election_timed_out;
  } out_word_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic advance;
  } stage_ctl_t;

endpackage

// File: hw/rtl/consensus_term_vote_tracker_core.sv
// Path: a word waits in the input register and its result goes to the result register.
// Throughput: one event word per cycle while the output side does not stall, set by the
// single update step that reads and writes the term and vote registers in the same cycle.
// Reset: asynchronous, active low; term, vote, counts, heartbeat flag and
// both stage valid flags clear at once, and a word is accepted right after.
module consensus_term_vote_tracker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctvt_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctvt_pkg::out_word_t out_data_o
);

  // The block is a two-register pipeline. The input stage holds one event
  // word. The engine applies it to the node state in the cycle that the word
  // moves on, so the next word always sees the state left by the one before.
  // The result register parts the output side from the input side: a new
  // word is taken while a finished result still waits to be taken.

  ctvt_pkg::stage_ctl_t s1_ctl;
  ctvt_pkg::in_word_t   s1_word;
  ctvt_pkg::out_word_t  result;
  logic                 out_ready;

  ctvt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .down_ready_i (out_ready),
    .ctl_o        (s1_ctl),
    .word_o       (s1_word)
  );

  // State changes only when a word advances, which keeps every event
  // counted exactly once however the output side stalls.
  ctvt_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s1_ctl),
    .word_i   (s1_word),
    .result_o (result)
  );

  ctvt_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s1_ctl),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/ctvt_in_stage.sv
module ctvt_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctvt_pkg::in_word_t  in_data_i,
  input  logic                down_ready_i,
  output ctvt_pkg::stage_ctl_t ctl_o,
  output ctvt_pkg::in_word_t  word_o
);

  logic               valid_q, valid_d;
  ctvt_pkg::in_word_t word_q;
  logic               take;

  // The held word leaves when the result register can take it.
  assign in_stall_o = valid_q && !down_ready_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_d    = take || (valid_q && !down_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= in_data_i;
    end
  end

  assign ctl_o.advance = valid_q && down_ready_i;
  assign word_o        = word_q;

endmodule

// File: hw/rtl/ctvt_engine.sv
module ctvt_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctvt_pkg::stage_ctl_t ctl_i,
  input  ctvt_pkg::in_word_t   word_i,
  output ctvt_pkg::out_word_t  result_o
);

  logic [ctvt_pkg::TermW-1:0] term_q, term_d;
  logic                       voted_q, voted_d;
  logic [ctvt_pkg::CntW-1:0]  votes_q, votes_d;
  logic [ctvt_pkg::CntW-1:0]  part_q, part_d;
  logic                       hb_q, hb_d;

  logic                       ge, gt;
  logic [ctvt_pkg::PartW-1:0] peers_w, peers_clip, part_sum;
  logic [ctvt_pkg::CntW-1:0]  part_new, votes_inc, need;
  logic                       ok, adv, leader, won, tout;

  always_comb begin
    ge = word_i.msg_term >= term_q;
    gt = word_i.msg_term > term_q;

    peers_w    = ctvt_pkg::PartW'(word_i.ready_peers);
    peers_clip = (peers_w > ctvt_pkg::MaxPeersW) ? ctvt_pkg::MaxPeersW : peers_w;
    part_sum   = peers_clip + ctvt_pkg::PartW'(1);
    part_new   = (part_sum > ctvt_pkg::PartW'(ctvt_pkg::CntMax)) ?
                 ctvt_pkg::CntMax : part_sum[ctvt_pkg::CntW-1:0];

    votes_inc = (votes_q == ctvt_pkg::CntMax) ? votes_q : votes_q + 1'b1;
    need      = (part_q >> 1) + 1'b1;

    term_d  = term_q;
    voted_d = voted_q;
    votes_d = votes_q;
    part_d  = part_q;
    hb_d    = hb_q;
    ok      = 1'b0;
    adv     = 1'b0;
    leader  = 1'b0;
    won     = 1'b0;
    tout    = 1'b0;

    case (word_i.kind)
      ctvt_pkg::KIND_HB_REQ: begin
        if (ge) begin
          ok     = 1'b1;
          leader = 1'b1;
          hb_d   = 1'b1;
        end
      end
      ctvt_pkg::KIND_VOTE_REQ: begin
        // After adopting a higher term the vote is free again.
        if (ge && (gt || !voted_q)) begin
          voted_d = 1'b1;
          ok      = 1'b1;
        end
      end
      ctvt_pkg::KIND_VOTE_REPLY: begin
        if (ge && !gt && word_i.granted_in) begin
          votes_d = votes_inc;
          won     = votes_inc >= need;
        end
      end
      ctvt_pkg::KIND_ELECTION: begin
        term_d  = (term_q == ctvt_pkg::TermMax) ? term_q : term_q + 1'b1;
        voted_d = 1'b1;
        votes_d = ctvt_pkg::CntW'(1);
        part_d  = part_new;
        // A lone node wins its own election at once.
        won     = part_new <= ctvt_pkg::CntW'(1);
      end
      ctvt_pkg::KIND_BROADCAST: begin
        part_d = part_new;
      end
      ctvt_pkg::KIND_TIMER: begin
        if (hb_q) begin
          hb_d = 1'b0;
        end else begin
          tout = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A higher term in any request or reply is adopted and clears the vote.
    if (gt && (word_i.kind == ctvt_pkg::KIND_HB_REQ ||
               word_i.kind == ctvt_pkg::KIND_VOTE_REQ ||
               word_i.kind == ctvt_pkg::KIND_VOTE_REPLY ||
               word_i.kind == ctvt_pkg::KIND_HB_REPLY)) begin
      adv     = 1'b1;
      term_d  = word_i.msg_term;
      votes_d = '0;
      if (word_i.kind != ctvt_pkg::KIND_VOTE_REQ) begin
        voted_d = 1'b0;
      end
    end

    result_o.reply_term         = term_d;
    result_o.reply_ok           = ok;
    result_o.term_advanced      = adv;
    result_o.leader_seen        = leader;
    result_o.elected            = won;
    result_o.election_timed_out = tout;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q  <= '0;
      voted_q <= 1'b0;
      votes_q <= '0;
      part_q  <= '0;
      hb_q    <= 1'b0;
    end else if (ctl_i.advance) begin
      term_q  <= term_d;
      voted_q <= voted_d;
      votes_q <= votes_d;
      part_q  <= part_d;
      hb_q    <= hb_d;
    end
  end

  a_term_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q >= $past(term_q))
    else $error("term went backwards");

  a_leader_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance && result_o.leader_seen |-> result_o.reply_ok)
    else $error("leader seen without accepted heartbeat");

  a_no_ok_and_elected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance |-> !(result_o.reply_ok && result_o.elected))
    else $error("reply ok and elected in one result");

  a_hold_without_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.advance |=> $stable(votes_q) && $stable(part_q) && $stable(voted_q))
    else $error("state changed without an event");

endmodule

// File: hw/rtl/ctvt_out_stage.sv
module ctvt_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctvt_pkg::stage_ctl_t ctl_i,
  input  ctvt_pkg::out_word_t  result_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ctvt_pkg::out_word_t  out_data_o
);

  logic                valid_q, valid_d;
  ctvt_pkg::out_word_t data_q;

  // Room when empty or when the held word is taken in this cycle.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ctl_i.advance || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import ctvt_pkg::*;

  // Kind code 7 has no meaning for the tracker. The block must pass it
  // through as a no-op that still produces a reply word.
  localparam logic [KindW-1:0] KindUnused = 3'd7;

  localparam int unsigned HeadRows    = 25;
  localparam int unsigned TailRows    = 4;
  localparam int unsigned RandomWords = 1400;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SettleWait  = 8;

  // One row of the directed table. When has_want is set, the reply is typed in
  // by hand. Otherwise the row is checked against the tracker prediction.
  typedef struct {
    in_word_t  word;
    bit        has_want;
    out_word_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_q = 1'b0;
  in_word_t  in_data_q = '0;
  logic      out_stall_q = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_data_o;

  // This is the tracker state as the testbench believes it to be. It is
  // updated at the edge where each input word is accepted.
  logic [TermW-1:0] trk_term = '0;
  logic             trk_voted = 1'b0;
  logic [CntW-1:0]  trk_votes = '0;
  logic [CntW-1:0]  trk_parts = '0;
  logic             trk_hb_seen = 1'b0;

  out_word_t   expected_replies[$];
  stim_row_t   stim_table[HeadRows + TailRows];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  consensus_term_vote_tracker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_q),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // The watchdog ends a run that hangs, for example on a lost reply or a
  // stall that never clears.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker prediction
  // ---------------------------------------------------------------------------

  // A strictly higher incoming term replaces ours and drops this term's vote
  // bookkeeping. An equal or lower term leaves everything alone.
  function automatic bit take_term(logic [TermW-1:0] t);
    if (t <= trk_term) return 1'b0;
    trk_term  = t;
    trk_voted = 1'b0;
    trk_votes = '0;
    return 1'b1;
  endfunction

  function automatic bit has_majority();
    return int'(trk_votes) >= int'(trk_parts >> 1) + 1;
  endfunction

  // The participant count is this node plus the peers it reached. The peers
  // are clamped to the configured maximum.
  function automatic void count_parts(logic [PeersW-1:0] peers);
    int unsigned p;
    p = (int'(peers) > MaxPeers) ? MaxPeers : int'(peers);
    p = p + 1;
    if (p > int'(CntMax)) p = int'(CntMax);
    trk_parts = CntW'(p);
  endfunction

  function automatic out_word_t track_event(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.kind)
      KIND_HB_REQ: begin
        // A heartbeat from a stale term is refused without any side effect.
        if (w.msg_term >= trk_term) begin
          r.term_advanced = take_term(w.msg_term);
          r.reply_ok      = 1'b1;
          r.leader_seen   = 1'b1;
          trk_hb_seen     = 1'b1;
        end
      end
      KIND_VOTE_REQ: begin
        r.term_advanced = take_term(w.msg_term);
        if (w.msg_term >= trk_term && !trk_voted) begin
          trk_voted  = 1'b1;
          r.reply_ok = 1'b1;
        end
      end
      KIND_VOTE_REPLY: begin
        // A reply that carries a newer term only moves us to that term. It
        // is never counted as a vote.
        if (w.msg_term >= trk_term) begin
          if (take_term(w.msg_term)) begin
            r.term_advanced = 1'b1;
          end else if (w.granted_in) begin
            if (trk_votes != CntMax) trk_votes = trk_votes + 1'b1;
            r.elected = has_majority();
          end
        end
      end
      KIND_HB_REPLY: begin
        if (w.msg_term >= trk_term) r.term_advanced = take_term(w.msg_term);
      end
      KIND_ELECTION: begin
        if (trk_term != TermMax) trk_term = trk_term + 1'b1;
        trk_voted = 1'b1;
        trk_votes = CntW'(1);
        count_parts(w.ready_peers);
        // A node with no peers wins on its own vote at once.
        if (trk_parts <= CntW'(1)) r.elected = has_majority();
      end
      KIND_BROADCAST: begin
        count_parts(w.ready_peers);
      end
      KIND_TIMER: begin
        if (trk_hb_seen) trk_hb_seen = 1'b0;
        else r.election_timed_out = 1'b1;
      end
      default: begin
      end
    endcase
    r.reply_term = trk_term;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic in_word_t mk_word(logic [KindW-1:0] kind, logic [TermW-1:0] term,
                                       logic granted, logic [PeersW-1:0] peers);
    in_word_t w;
    w.kind        = kind;
    w.msg_term    = term;
    w.granted_in  = granted;
    w.ready_peers = peers;
    return w;
  endfunction

  function automatic out_word_t mk_reply(logic [TermW-1:0] term, logic ok, logic adv,
                                         logic leader, logic won, logic tout);
    out_word_t r;
    r.reply_term         = term;
    r.reply_ok           = ok;
    r.term_advanced      = adv;
    r.leader_seen        = leader;
    r.elected            = won;
    r.election_timed_out = tout;
    return r;
  endfunction

  // Produce a term close to the current one: a little below it, equal to it,
  // or a little above it. The result is clamped at both ends of the range.
  function automatic logic [TermW-1:0] term_near();
    logic [TermW-1:0] d;
    d = TermW'($urandom_range(1, 4));
    case ($urandom_range(0, 5))
      0, 1:    return (trk_term >= d) ? trk_term - d : '0;
      2, 3:    return trk_term;
      default: return (TermMax - trk_term >= d) ? trk_term + d : TermMax;
    endcase
  endfunction

  // Offer one word and hold it until it is accepted. Idle gaps are inserted
  // between bursts here. The valid signal is lowered only when a gap starts,
  // so a word that follows directly is never lowered and raised in the same
  // step. The expected reply is queued at the edge of acceptance.
  task automatic put_word(input in_word_t w, input bit has_want, input out_word_t want);
    out_word_t predicted;
    if (burst_left == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 25);
    end
    burst_left--;
    in_data_q  <= w;
    in_valid_q <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = track_event(w);
    expected_replies.insert(expected_replies.size(), has_want ? want : predicted);
    words_sent++;
  endtask

  task automatic put_random(input in_word_t w);
    put_word(w, 1'b0, '0);
  endtask

  // The sender stops and waits until every reply that it is owed has come.
  task automatic drain_replies();
    in_valid_q <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern, long hold-off and reply checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH (%s) at reply %0d: got term %h ok %b adv %b lead %b won %b tout %b,",
               what, results_seen, got.reply_term, got.reply_ok, got.term_advanced,
               got.leader_seen, got.elected, got.election_timed_out);
      $display("  want term %h ok %b adv %b lead %b won %b tout %b",
               want.reply_term, want.reply_ok, want.term_advanced,
               want.leader_seen, want.elected, want.election_timed_out);
    end
  endtask

  // The receiver stalls on a 16-bit pattern that is replaced each time its
  // phase wraps. Some patterns never stall, some stall lightly, some stall heavily.
  // Twice in the run the receiver holds off for a long stretch, counted here.
  // During that time the sender keeps offering words, so the block fills up
  // and stalls its own input.
  logic [15:0] stall_pat = '0;
  logic [7:0]  pat_phase = '0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin : reply_check
    out_word_t want;
    bit        bad;
    if (rst_ni && out_valid_o && !out_stall_q) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected word", out_data_o, '0);
      end else begin
        want = expected_replies.pop_front();
        bad  = (out_data_o.reply_term !== want.reply_term);
        bad |= (out_data_o.reply_ok !== want.reply_ok);
        bad |= (out_data_o.term_advanced !== want.term_advanced);
        bad |= (out_data_o.leader_seen !== want.leader_seen);
        bad |= (out_data_o.elected !== want.elected);
        bad |= (out_data_o.election_timed_out !== want.election_timed_out);
        if (bad) report_mismatch("field", out_data_o, want);
      end
      results_seen++;
      if (results_seen == 300 || results_seen == 900) hold_left = HoldCycles;
    end
    pat_phase <= pat_phase + 1'b1;
    if (pat_phase == '1) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= '0;
        1:       stall_pat <= 16'($urandom);
        2:       stall_pat <= 16'($urandom) & 16'($urandom);
        default: stall_pat <= 16'($urandom) | 16'($urandom);
      endcase
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_q <= 1'b1;
    end else begin
      out_stall_q <= stall_pat[pat_phase[3:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned n;
    bit          paused_once;
    bit          jumped_high;
    logic [TermW-1:0] t;

    // This is the directed head. It starts right after reset with all
    // tracker state at zero.
    stim_table[0]  = '{mk_word(KIND_TIMER, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)};    // no heartbeat yet
    stim_table[1]  = '{mk_word(KIND_HB_REQ, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply('0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)};    // equal term accepted
    stim_table[2]  = '{mk_word(KIND_TIMER, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)};    // heartbeat clears it
    stim_table[3]  = '{mk_word(KIND_VOTE_REQ, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply('0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)};    // first vote granted
    stim_table[4]  = '{mk_word(KIND_VOTE_REQ, '0, 1'b1, 4'd0), 1'b1,
                       mk_reply('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)};    // already voted
    stim_table[5]  = '{mk_word(KIND_ELECTION, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply(64'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0)}; // lone node wins
    stim_table[6]  = '{mk_word(KIND_VOTE_REPLY, 64'd1, 1'b1, 4'd0), 1'b0, '0};
    stim_table[7]  = '{mk_word(KIND_BROADCAST, TermMax, 1'b1, 4'd15), 1'b1,
                       mk_reply(64'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)}; // term ignored here
    stim_table[8]  = '{mk_word(KIND_VOTE_REPLY, 64'd1, 1'b0, 4'd0), 1'b0, '0};
    stim_table[9]  = '{mk_word(KIND_VOTE_REPLY, '0, 1'b1, 4'd0), 1'b0, '0};
    stim_table[10] = '{mk_word(KIND_HB_REQ, '0, 1'b0, 4'd0), 1'b1,
                       mk_reply(64'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)}; // stale heartbeat
    stim_table[11] = '{mk_word(KIND_HB_REPLY, 64'd5, 1'b0, 4'd0), 1'b1,
                       mk_reply(64'd5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)}; // newer term adopted
    stim_table[12] = '{mk_word(KIND_VOTE_REQ, 64'd5, 1'b0, 4'd0), 1'b0, '0};
    stim_table[13] = '{mk_word(KIND_VOTE_REPLY, 64'd6, 1'b1, 4'd0), 1'b0, '0};
    stim_table[14] = '{mk_word(KindUnused, TermMax, 1'b1, 4'd15), 1'b1,
                       mk_reply(64'd6, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)}; // unused kind
    stim_table[15] = '{mk_word(KIND_ELECTION, '0, 1'b0, 4'd15), 1'b0, '0};
    // Eight granted replies bring the vote count to 9 of 16, which wins on
    // the last of them.
    for (int i = 16; i < 24; i++)
      stim_table[i] = '{mk_word(KIND_VOTE_REPLY, 64'd7, 1'b1, 4'd0), 1'b0, '0};
    stim_table[24] = '{mk_word(KIND_VOTE_REQ, 64'd7, 1'b0, 4'd0), 1'b0, '0};
    // The tail runs at the top of the term range. Once the term reaches its
    // maximum it stays there until the end of the run.
    stim_table[25] = '{mk_word(KIND_HB_REQ, TermMax, 1'b0, 4'd0), 1'b0, '0};
    stim_table[26] = '{mk_word(KIND_ELECTION, '0, 1'b0, 4'd2), 1'b0, '0};
    stim_table[27] = '{mk_word(KIND_VOTE_REPLY, TermMax, 1'b1, 4'd0), 1'b0, '0};
    stim_table[28] = '{mk_word(KIND_TIMER, TermMax, 1'b1, 4'd15), 1'b0, '0};

    paused_once = 1'b0;
    jumped_high = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < HeadRows; i++)
      put_word(stim_table[i].word, stim_table[i].has_want, stim_table[i].want);

    // In the random part, most of the traffic is well-formed exchanges:
    // election campaigns with vote replies, follower traffic with heartbeats
    // and vote requests, and broadcast rounds. The rest is noise. Terms stay
    // near the current one so that equal, lower and higher terms all occur.
    while (words_sent < HeadRows + RandomWords) begin
      if (!paused_once && words_sent >= HeadRows + RandomWords / 2) begin
        drain_replies();
        paused_once = 1'b1;
      end
      // Late in the run the term moves near the top of its range, so that
      // the saturation behavior can be reached.
      if (!jumped_high && words_sent >= HeadRows + RandomWords - 150) begin
        t = TermMax - TermW'($urandom_range(64, 4096));
        put_random(mk_word(KIND_HB_REPLY, t, 1'($urandom), 4'($urandom)));
        jumped_high = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // This is a campaign. Long runs of replies push the vote count
          // into saturation.
          put_random(mk_word(KIND_ELECTION, {$urandom, $urandom}, 1'($urandom),
                             ($urandom_range(0, 2) == 0) ? 4'($urandom) :
                             4'($urandom_range(0, 4))));
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 10);
          repeat (n)
            put_random(mk_word(KIND_VOTE_REPLY,
                               ($urandom_range(0, 7) == 0) ? term_near() : trk_term,
                               $urandom_range(0, 6) != 0, 4'($urandom)));
        end
        4, 5: begin
          // This is follower traffic: a leader's heartbeat, timer expiries, then vote
          // requests and a heartbeat reply with terms near the current one.
          put_random(mk_word(KIND_HB_REQ, term_near(), 1'($urandom), 4'($urandom)));
          repeat ($urandom_range(1, 3))
            put_random(mk_word(KIND_TIMER, {$urandom, $urandom}, 1'($urandom),
                               4'($urandom)));
          put_random(mk_word(KIND_VOTE_REQ, term_near(), 1'($urandom), 4'($urandom)));
          put_random(mk_word(KIND_VOTE_REQ, term_near(), 1'($urandom), 4'($urandom)));
          put_random(mk_word(KIND_HB_REPLY, term_near(), 1'($urandom), 4'($urandom)));
        end
        6: begin
          put_random(mk_word(KIND_BROADCAST, {$urandom, $urandom}, 1'($urandom),
                             4'($urandom)));
          repeat ($urandom_range(1, 5))
            put_random(mk_word(KIND_HB_REPLY, term_near(), 1'($urandom), 4'($urandom)));
        end
        default: begin
          // This is noise: any kind. Kinds that carry no term get a full-width
          // random term, which must have no effect.
          n = $urandom_range(0, 7);
          if (n >= 4)
            put_random(mk_word(KindW'(n), {$urandom, $urandom}, 1'($urandom),
                               4'($urandom)));
          else
            put_random(mk_word(KindW'(n), term_near(), 1'($urandom), 4'($urandom)));
        end
      endcase
    end

    drain_replies();
    for (int i = HeadRows; i < HeadRows + TailRows; i++)
      put_word(stim_table[i].word, stim_table[i].has_want, stim_table[i].want);

    in_valid_q <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    // This extra wait catches any word that the block sends beyond the last
    // expected reply.
    repeat (SettleWait) @(posedge clk_i);

    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
